### src/lbs_pkg.sv
// Shared types, constants and helpers of the linear blend vertex skinner.
package lbs_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int FRAC_BITS       = 16;
  localparam int WORDS_PER_ENTRY = 12;
  localparam int PAL_WORDS       = PALETTE_ENTRIES * WORDS_PER_ENTRY;
  localparam int ENTRY_W         = $clog2(PALETTE_ENTRIES);
  localparam int WORD_W          = $clog2(WORDS_PER_ENTRY);
  localparam int MAX_BONES       = 4;
  localparam int BONE_W          = $clog2(MAX_BONES);

  // Configuration register indexes.
  localparam logic REG_NUM_WEIGHTS      = 1'b0;
  localparam logic REG_HAS_BONE_INDICES = 1'b1;

  // Request function codes.
  localparam logic FUNC_PAL_WRITE = 1'b0;
  localparam logic FUNC_SKIN      = 1'b1;

  typedef logic signed [31:0] word_t;

  // One bone of one vertex entering the arithmetic pipeline.
  typedef struct packed {
    logic             valid;
    logic             last;
    word_t            weight;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] nrm;
  } lbs_bone_t;

  // Finished vertex leaving the accumulator.
  typedef struct packed {
    logic             valid;
    logic [5:0][31:0] val;
  } lbs_result_t;

  function automatic word_t sat32(input logic signed [63:0] v);
    word_t r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### src/lbs_if.sv
// Request and result channel interfaces of the skinner.
interface lbs_in_if;
  logic         valid;
  logic         ready;
  logic         func;
  logic [11:0]  pal_address;
  logic signed [31:0] pal_value;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] nrm_x;
  logic signed [31:0] nrm_y;
  logic signed [31:0] nrm_z;
  logic [63:0]  weights_01;
  logic signed [31:0] weight_2;
  logic [31:0]  bone_indices;

  modport source (output valid, func, pal_address, pal_value, pos_x, pos_y, pos_z,
                  nrm_x, nrm_y, nrm_z, weights_01, weight_2, bone_indices,
                  input ready);
  modport sink (input valid, func, pal_address, pal_value, pos_x, pos_y, pos_z,
                nrm_x, nrm_y, nrm_z, weights_01, weight_2, bone_indices,
                output ready);
endinterface

interface lbs_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic signed [31:0] out_pos_z;
  logic signed [31:0] out_nrm_x;
  logic signed [31:0] out_nrm_y;
  logic signed [31:0] out_nrm_z;

  modport source (output valid, out_pos_x, out_pos_y, out_pos_z,
                  out_nrm_x, out_nrm_y, out_nrm_z, input ready);
  modport sink (input valid, out_pos_x, out_pos_y, out_pos_z,
                out_nrm_x, out_nrm_y, out_nrm_z, output ready);
endinterface

### src/lbs_palette.sv
// Bone matrix palette: twelve word banks, one entry read per cycle while re is high.
module lbs_palette
  import lbs_pkg::*;
(
  input  logic                               clk,
  input  logic                               we,
  input  logic [11:0]                        waddr,
  input  word_t                              wdata,
  input  logic                               re,
  input  logic [ENTRY_W-1:0]                 raddr,
  output logic [WORDS_PER_ENTRY-1:0][31:0]   rdata
);

  logic [24:0]        addr_prod;
  logic [ENTRY_W-1:0] w_entry;
  logic [WORD_W-1:0]  w_word;
  logic               w_ok;
  logic [15:0]        entry_x12;

  // The word address is split by a multiply with the reciprocal of twelve;
  // the error stays below one twelfth for every address in range.
  assign addr_prod = 25'(waddr) * 25'd5462;
  assign w_entry   = addr_prod[16 +: ENTRY_W];
  assign entry_x12 = 16'(w_entry) * 16'(WORDS_PER_ENTRY);
  assign w_word    = WORD_W'(16'(waddr) - entry_x12);
  assign w_ok      = 32'(waddr) < PAL_WORDS;

  for (genvar b = 0; b < WORDS_PER_ENTRY; b++) begin : g_bank
    logic [31:0] mem [PALETTE_ENTRIES];

    always_ff @(posedge clk) begin
      if (we && w_ok && (w_word == WORD_W'(b))) begin
        mem[w_entry] <= wdata;
      end
      if (re) begin
        rdata[b] <= mem[raddr];
      end
    end
  end

endmodule

### src/lbs_bone_pipe.sv
// Per-bone transform, weighting and accumulation pipeline.
module lbs_bone_pipe
  import lbs_pkg::*;
(
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  lbs_bone_t                        bone,
  input  logic [WORDS_PER_ENTRY-1:0][31:0] mat,
  output lbs_result_t                      result
);

  // Stage 1: matrix words arrive from the palette alongside the vertex.
  lbs_bone_t s1;

  // Stage 2: shifted row-by-vector products.
  logic        s2_valid, s2_last;
  word_t       s2_w;
  logic signed [63:0] s2_pp [9];
  logic signed [63:0] s2_np [9];
  word_t       s2_t [3];

  // Stage 3: saturated row sums.
  logic        s3_valid, s3_last;
  word_t       s3_w;
  word_t       s3_r [6];

  // Stage 4: weighted contributions.
  logic        s4_valid, s4_last;
  logic signed [63:0] s4_c [6];

  logic signed [63:0] acc [6];
  logic signed [63:0] acc_sum [6];
  logic               fresh;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      fresh    <= 1'b1;
    end else if (en) begin
      s1.valid <= bone.valid;
      s2_valid <= s1.valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      if (s4_valid) begin
        fresh <= s4_last;
      end
    end

    if (en) begin
      s1.last   <= bone.last;
      s1.weight <= bone.weight;
      s1.pos    <= bone.pos;
      s1.nrm    <= bone.nrm;

      s2_last <= s1.last;
      s2_w    <= s1.weight;
      for (int r = 0; r < 3; r++) begin
        s2_t[r] <= $signed(mat[r*4+3]);
        for (int c = 0; c < 3; c++) begin
          s2_pp[r*3+c] <= ($signed(mat[r*4+c]) * $signed(s1.pos[c])) >>> FRAC_BITS;
          s2_np[r*3+c] <= ($signed(mat[r*4+c]) * $signed(s1.nrm[c])) >>> FRAC_BITS;
        end
      end

      s3_last <= s2_last;
      s3_w    <= s2_w;
      for (int r = 0; r < 3; r++) begin
        s3_r[r]   <= sat32(s2_pp[r*3] + s2_pp[r*3+1] + s2_pp[r*3+2] + 64'(s2_t[r]));
        s3_r[3+r] <= sat32(s2_np[r*3] + s2_np[r*3+1] + s2_np[r*3+2]);
      end

      s4_last <= s3_last;
      for (int k = 0; k < 6; k++) begin
        s4_c[k] <= (64'(s3_r[k]) * 64'(s3_w)) >>> FRAC_BITS;
      end

      if (s4_valid) begin
        for (int k = 0; k < 6; k++) begin
          acc[k] <= acc_sum[k];
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      acc_sum[k] = (fresh ? 64'sd0 : acc[k]) + s4_c[k];
    end
  end

  always_comb begin
    result.valid = s4_valid && s4_last;
    for (int k = 0; k < 6; k++) begin
      result.val[k] = sat32(acc_sum[k]);
    end
  end

endmodule

### src/linear_blend_vertex_skinning.sv
// Top level of the linear blend vertex skinner.
// A palette write request does not occupy the skinner. A skin request issues
// one blended bone after another, num_weights + 1 bones (one to four), through
// the single palette read port that fetches one whole bone matrix per cycle
// unless a finished result waits downstream; a new request is taken in the
// cycle that issues the last bone of the previous one. Each bone then passes
// four register stages (palette read, row products, row sums, weighting) and
// is added into the running sum on its way into the output register.
module linear_blend_vertex_skinning
  import lbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  lbs_in_if.sink      in_ch,
  lbs_out_if.source   out_ch
);

  logic [1:0] num_weights;
  logic       has_bone_indices;

  logic       en;
  logic       accept;
  logic       busy;
  logic       last_issue;
  logic [BONE_W-1:0] bj;
  logic [1:0]        vnw;
  logic [31:0]       vidx;
  word_t             vw [MAX_BONES];
  logic [2:0][31:0]  vpos;
  logic [2:0][31:0]  vnrm;

  word_t              win [3];
  logic signed [33:0] wsum;
  word_t              wimp;
  word_t              wsel [MAX_BONES];

  lbs_bone_t                        bone;
  logic [WORDS_PER_ENTRY-1:0][31:0] mat;
  lbs_result_t                      result;
  logic [31:0]                      idx_shift;

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_weights      <= 2'd0;
      has_bone_indices <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_NUM_WEIGHTS:      num_weights      <= pwdata[1:0];
        REG_HAS_BONE_INDICES: has_bone_indices <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_NUM_WEIGHTS:      prdata = {30'd0, num_weights};
      REG_HAS_BONE_INDICES: prdata = {31'd0, has_bone_indices};
      default:              prdata = 32'd0;
    endcase
  end

  // The whole pipeline advances unless a finished result waits downstream.
  assign en         = !out_ch.valid || out_ch.ready;
  assign last_issue = busy && (bj == vnw);
  assign in_ch.ready = en && (!busy || last_issue);
  assign accept     = in_ch.valid && in_ch.ready;

  // Explicit weights and the implicit one that completes them to unity.
  always_comb begin
    win[0] = in_ch.weights_01[31:0];
    win[1] = in_ch.weights_01[63:32];
    win[2] = in_ch.weight_2;
    wsum   = 34'sd0;
    for (int j = 0; j < 3; j++) begin
      if (2'(j) < num_weights) begin
        wsum = wsum + 34'(win[j]);
      end
    end
    wimp = sat32((64'sd1 <<< FRAC_BITS) - 64'(wsum));
    for (int j = 0; j < MAX_BONES; j++) begin
      if (2'(j) == num_weights) begin
        wsel[j] = wimp;
      end else if (j < 3 && 2'(j) < num_weights) begin
        wsel[j] = win[j < 3 ? j : 0];
      end else begin
        wsel[j] = 32'sd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      bj   <= '0;
    end else if (accept && in_ch.func == FUNC_SKIN) begin
      busy <= 1'b1;
      bj   <= '0;
    end else if (en && busy) begin
      bj <= bj + 1'b1;
      if (last_issue) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_ch.func == FUNC_SKIN) begin
      vnw  <= num_weights;
      vidx <= has_bone_indices ? in_ch.bone_indices : 32'h0000_0100;
      for (int j = 0; j < MAX_BONES; j++) begin
        vw[j] <= wsel[j];
      end
      vpos <= {in_ch.pos_z, in_ch.pos_y, in_ch.pos_x};
      vnrm <= {in_ch.nrm_z, in_ch.nrm_y, in_ch.nrm_x};
    end
  end

  assign idx_shift   = vidx >> {bj, 3'b000};
  assign bone.valid  = busy;
  assign bone.last   = last_issue;
  assign bone.weight = vw[bj];
  assign bone.pos    = vpos;
  assign bone.nrm    = vnrm;

  lbs_palette u_palette (
    .clk   (clk),
    .we    (accept && in_ch.func == FUNC_PAL_WRITE),
    .waddr (in_ch.pal_address),
    .wdata (in_ch.pal_value),
    .re    (en),
    .raddr (idx_shift[ENTRY_W-1:0]),
    .rdata (mat)
  );

  lbs_bone_pipe u_bone_pipe (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .bone   (bone),
    .mat    (mat),
    .result (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (en) begin
      out_ch.valid <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && result.valid) begin
      out_ch.out_pos_x <= result.val[0];
      out_ch.out_pos_y <= result.val[1];
      out_ch.out_pos_z <= result.val[2];
      out_ch.out_nrm_x <= result.val[3];
      out_ch.out_nrm_y <= result.val[4];
      out_ch.out_nrm_z <= result.val[5];
    end
  end

endmodule

### sim/tb_top.sv
// Self-checking testbench for the linear blend vertex skinner.
`timescale 1ns / 100ps

module tb_top;
  import lbs_pkg::*;

  typedef struct {
    bit              func;
    bit [11:0]       pal_address;
    bit [31:0]       pal_value;
    bit [2:0][31:0]  pos;
    bit [2:0][31:0]  nrm;
    bit [63:0]       weights_01;
    bit [31:0]       weight_2;
    bit [31:0]       bone_indices;
  } skin_req_t;

  typedef struct {
    skin_req_t      req;
    bit             has_vertex;
    bit [5:0][31:0] vertex;
  } pending_req_t;

  localparam int TIMEOUT_CYCLES = 200000;
  localparam int SETTLE_CYCLES  = 20;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lbs_in_if  in_ch ();
  lbs_out_if out_ch ();

  linear_blend_vertex_skinning dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  // Predictor state.
  int          palette [PAL_WORDS];
  bit          word_written [PAL_WORDS];
  int          ready_entries [$];
  bit [1:0]    cur_num_weights;
  bit          cur_has_indices;

  pending_req_t   request_queue [$];
  bit [5:0][31:0] vertex_expect [$];
  pending_req_t   in_flight;

  int errors = 0;
  int cycle_count = 0;
  int vertices_checked = 0;
  int palette_writes;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // No idling on either side during a stretch in the middle of the run.
  function automatic bit idle_roll();
    return (cycle_count < 400 || cycle_count > 800) && ($urandom_range(99) < 8);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready && in_flight.has_vertex) begin
        vertex_expect.push_back(in_flight.vertex);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (request_queue.size() > 0 && !idle_roll()) begin
          in_flight = request_queue.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.func         <= in_flight.req.func;
          in_ch.pal_address  <= in_flight.req.pal_address;
          in_ch.pal_value    <= in_flight.req.pal_value;
          in_ch.pos_x        <= in_flight.req.pos[0];
          in_ch.pos_y        <= in_flight.req.pos[1];
          in_ch.pos_z        <= in_flight.req.pos[2];
          in_ch.nrm_x        <= in_flight.req.nrm[0];
          in_ch.nrm_y        <= in_flight.req.nrm[1];
          in_ch.nrm_z        <= in_flight.req.nrm[2];
          in_ch.weights_01   <= in_flight.req.weights_01;
          in_ch.weight_2     <= in_flight.req.weight_2;
          in_ch.bone_indices <= in_flight.req.bone_indices;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and checker.
  always @(posedge clk) begin
    bit [5:0][31:0] got;
    bit [5:0][31:0] want;
    string names [6];
    names = '{"out_pos_x", "out_pos_y", "out_pos_z", "out_nrm_x", "out_nrm_y", "out_nrm_z"};
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !idle_roll();
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.out_nrm_z, out_ch.out_nrm_y, out_ch.out_nrm_x,
               out_ch.out_pos_z, out_ch.out_pos_y, out_ch.out_pos_x};
        if (vertex_expect.size() == 0) begin
          $error("unexpected vertex result");
          errors++;
        end else begin
          want = vertex_expect.pop_front();
          vertices_checked++;
          for (int k = 0; k < 6; k++) begin
            if (got[k] !== want[k]) begin
              $error("%s expected %h actual %h", names[k], want[k], got[k]);
              errors++;
            end
          end
        end
      end
    end
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint to_long(bit [31:0] v);
    return longint'($signed(v));
  endfunction

  // One matrix row times a vector, each product truncated before the sum.
  function automatic longint row_times(int base, longint v [3], bit translate);
    longint s;
    s = 0;
    for (int c = 0; c < 3; c++) begin
      s += (longint'(palette[base + c]) * v[c]) >>> FRAC_BITS;
    end
    if (translate) s += longint'(palette[base + 3]);
    return clamp32(s);
  endfunction

  function automatic bit [5:0][31:0] blend_vertex(skin_req_t r);
    longint p [3];
    longint n [3];
    longint w [4];
    longint acc [6];
    longint wsum;
    bit [31:0] idx;
    int base;
    bit [5:0][31:0] res;
    for (int k = 0; k < 3; k++) begin
      p[k] = to_long(r.pos[k]);
      n[k] = to_long(r.nrm[k]);
    end
    w[0] = to_long(r.weights_01[31:0]);
    w[1] = to_long(r.weights_01[63:32]);
    w[2] = to_long(r.weight_2);
    w[3] = 0;
    wsum = 0;
    for (int j = 0; j < cur_num_weights; j++) wsum += w[j];
    // The last bone takes whatever weight is left to reach one.
    w[cur_num_weights] = clamp32((64'sd1 <<< FRAC_BITS) - wsum);
    idx = cur_has_indices ? r.bone_indices : 32'h100;
    for (int k = 0; k < 6; k++) acc[k] = 0;
    for (int j = 0; j <= cur_num_weights; j++) begin
      if (w[j] != 0) begin
        base = (int'(idx[7:0]) % PALETTE_ENTRIES) * WORDS_PER_ENTRY;
        for (int row = 0; row < 3; row++) begin
          acc[row]     += (row_times(base + row * 4, p, 1'b1) * w[j]) >>> FRAC_BITS;
          acc[3 + row] += (row_times(base + row * 4, n, 1'b0) * w[j]) >>> FRAC_BITS;
        end
      end
      idx = idx >> 8;
    end
    for (int k = 0; k < 6; k++) res[k] = clamp32(acc[k]);
    return res;
  endfunction

  function automatic bit [31:0] rand_word();
    case ($urandom_range(9))
      0: return $urandom();
      1: case ($urandom_range(3))
           0: return 32'h8000_0000;
           1: return 32'h7FFF_FFFF;
           2: return 32'h0;
           default: return 32'hFFFF_FFFF;
         endcase
      default: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  function automatic bit [31:0] rand_weight();
    case ($urandom_range(9))
      0: return 32'h0;
      1: return $urandom();
      default: return $urandom_range(32'h0001_0000);
    endcase
  endfunction

  task automatic push_palette_write(bit [11:0] addr, bit [31:0] value);
    pending_req_t p;
    int e;
    bit full;
    p = '{default: '0};
    p.req.func = FUNC_PAL_WRITE;
    p.req.pal_address = addr;
    p.req.pal_value = value;
    // Position and bone index fields are junk on a palette write.
    p.req.pos = {$urandom(), $urandom(), $urandom()};
    p.req.bone_indices = $urandom();
    if (addr < PAL_WORDS) begin
      palette[addr] = int'(value);
      word_written[addr] = 1'b1;
      e = addr / WORDS_PER_ENTRY;
      full = 1'b1;
      for (int k = 0; k < WORDS_PER_ENTRY; k++) full &= word_written[e * WORDS_PER_ENTRY + k];
      if (full && !(e inside {ready_entries})) ready_entries.push_back(e);
    end
    palette_writes++;
    request_queue.push_back(p);
  endtask

  task automatic push_entry(int e, bit extreme);
    for (int k = 0; k < WORDS_PER_ENTRY; k++) begin
      push_palette_write(12'(e * WORDS_PER_ENTRY + k),
                         extreme ? (k[0] ? 32'h7FFF_FFFF : 32'h8000_0000) : rand_word());
    end
  endtask

  function automatic bit [7:0] pick_entry();
    return 8'(ready_entries[$urandom_range(ready_entries.size() - 1)]);
  endfunction

  task automatic push_vertex(bit [2:0][31:0] pos, bit [2:0][31:0] nrm,
                             bit [63:0] w01, bit [31:0] w2, bit [31:0] idx);
    pending_req_t p;
    p.req = '{default: '0};
    p.req.func = FUNC_SKIN;
    p.req.pal_address = $urandom();
    p.req.pal_value = $urandom();
    p.req.pos = pos;
    p.req.nrm = nrm;
    p.req.weights_01 = w01;
    p.req.weight_2 = w2;
    p.req.bone_indices = idx;
    p.has_vertex = 1'b1;
    p.vertex = blend_vertex(p.req);
    request_queue.push_back(p);
  endtask

  task automatic push_random_vertex();
    push_vertex({rand_word(), rand_word(), rand_word()},
                {rand_word(), rand_word(), rand_word()},
                {rand_weight(), rand_weight()}, rand_weight(),
                {pick_entry(), pick_entry(), pick_entry(), pick_entry()});
  endtask

  task automatic apb_write(bit reg_index, bit [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(bit [1:0] nw, bit has_idx);
    apb_write(REG_NUM_WEIGHTS, 32'(nw));
    apb_write(REG_HAS_BONE_INDICES, 32'(has_idx));
    cur_num_weights = nw;
    cur_has_indices = has_idx;
  endtask

  task automatic drain();
    while (request_queue.size() > 0 || in_ch.valid || vertex_expect.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 4) begin
        push_entry($urandom_range(PALETTE_ENTRIES - 1), 1'b0);
      end else if (r < 8) begin
        push_palette_write(12'($urandom_range(4095, PAL_WORDS)), $urandom());
      end else if (r < 14) begin
        push_palette_write(12'(pick_entry() * WORDS_PER_ENTRY
                               + $urandom_range(WORDS_PER_ENTRY - 1)), rand_word());
      end else begin
        push_random_vertex();
      end
    end
  endtask

  initial begin
    bit [1:0] nw_list [6];
    bit       idx_list [6];
    nw_list  = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd3, 2'd0};
    idx_list = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    palette_writes = 0;
    cur_num_weights = 0;
    cur_has_indices = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Preload a few full matrices; entry 255 holds only extreme words.
    configure(2'd3, 1'b1);
    foreach (nw_list[i]) push_entry(i == 3 ? 85 : (i == 4 ? 170 : (i == 5 ? 128 : i)), 1'b0);
    push_entry(127, 1'b0);
    push_entry(255, 1'b1);

    // Directed vertices: extreme inputs, zero weights, implicit weight of zero,
    // saturation through the extreme matrix, out-of-range palette writes.
    push_vertex({3{32'h7FFF_FFFF}}, {3{32'h8000_0000}}, {2{32'h0001_0000}},
                32'h0001_0000, 32'hFFFF_FFFF);
    push_vertex({3{32'h8000_0000}}, {3{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}},
                32'h8000_0000, 32'h7F80_55AA);
    push_vertex({3{32'h0001_0000}}, {3{32'h0001_0000}}, {32'h0000_8000, 32'h0000_4000},
                32'h0000_4000, 32'h0102_0055);
    push_vertex({3{32'h0}}, {3{32'h0}}, 64'h0, 32'h0, 32'h0000_0000);
    push_vertex({3{32'hFFFF_FFFF}}, {3{32'h0001_8000}}, {32'h8000_0000, 32'h8000_0000},
                32'h8000_0000, 32'hFF01_AA02);
    push_vertex({32'h0012_3456, 32'hFFED_CBA9, 32'h0100_0000}, {3{32'h0000_FFFF}},
                {32'h0, 32'h0001_0000}, 32'h0, 32'h00FF_0180);
    push_palette_write(12'hFFF, 32'hDEAD_BEEF);
    push_palette_write(12'(PAL_WORDS), 32'h1234_5678);
    push_palette_write(12'h000, 32'h0001_0000);
    push_vertex({3{32'h0002_0000}}, {3{32'hFFFE_0000}}, {2{32'h0000_4000}},
                32'h0000_4000, 32'h0000_0000);
    drain();

    foreach (nw_list[i]) begin
      configure(nw_list[i], idx_list[i]);
      random_phase(17);
      // Hold the sender back until every vertex in flight has come out.
      drain();
      random_phase(17);
      drain();
    end

    $display("Checked %0d skinned vertices against %0d palette writes over six settings.",
             vertices_checked, palette_writes);
    if (errors == 0 && vertex_expect.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
